// ===== sv/slfc_pkg.sv =====
// Shared constants and types for the sync/length frame checker.
package slfc_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;

    // Configuration port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index codes (taken from paddr[2])
    localparam logic REG_SYNC_VALUE = 1'b0;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET = 8'h7A;

    // Frame layout: two header bytes plus the length byte, then payload and checksum
    localparam logic [COUNT_W-1:0] HEADER_SPAN = 9'd3;
    localparam logic [COUNT_W-1:0] CHECK_BYTES = 9'd1;

    // One result item
    typedef struct packed {
        logic                 stored;
        logic [BYTE_W-1:0]    data;
        logic [COUNT_W-1:0]   position;
        logic                 verdict_valid;
        logic                 checksum_ok;
        logic [COUNT_W-1:0]   frame_length;
    } result_t;

endpackage

// ===== sv/slfc_in_if.sv =====
// Byte input channel of the frame checker.
interface slfc_in_if;

    logic                        valid;
    logic                        ready;
    logic [slfc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

// ===== sv/slfc_out_if.sv =====
// Result output channel of the frame checker.
interface slfc_out_if;

    logic                         valid;
    logic                         ready;
    logic                         stored;
    logic [slfc_pkg::BYTE_W-1:0]  data;
    logic [slfc_pkg::COUNT_W-1:0] position;
    logic                         verdict_valid;
    logic                         checksum_ok;
    logic [slfc_pkg::COUNT_W-1:0] frame_length;

    modport source (
        output valid, input ready,
        output stored, output data, output position,
        output verdict_valid, output checksum_ok, output frame_length
    );
    modport sink (
        input valid, output ready,
        input stored, input data, input position,
        input verdict_valid, input checksum_ok, input frame_length
    );

endinterface

// ===== sv/slfc_core.sv =====
// Frame tracking state and per-byte result logic of the frame checker.
module slfc_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [slfc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [slfc_pkg::BYTE_W-1:0]  sync_value,
    output slfc_pkg::result_t            result
);

    logic [slfc_pkg::COUNT_W-1:0] remaining_reg;
    logic [slfc_pkg::COUNT_W-1:0] remaining_next;
    logic [slfc_pkg::COUNT_W-1:0] remaining_ext;
    logic                         awaiting_reg;
    logic                         awaiting_next;
    logic [slfc_pkg::COUNT_W-1:0] count_reg;
    logic [slfc_pkg::COUNT_W-1:0] count_next;
    logic [slfc_pkg::BYTE_W-1:0]  sum_reg;
    logic [slfc_pkg::BYTE_W-1:0]  sum_next;
    logic [slfc_pkg::BYTE_W-1:0]  last_reg;
    logic [slfc_pkg::BYTE_W-1:0]  last_next;
    logic [slfc_pkg::BYTE_W-1:0]  sum_less_last;

    assign sum_less_last = sum_reg - last_reg;

    // Work out the result and the next frame state for the byte in hand
    always_comb
    begin
        result               = '0;
        result.data          = rx_byte;
        remaining_ext        = remaining_reg;
        remaining_next       = remaining_reg;
        awaiting_next        = awaiting_reg;
        count_next           = count_reg;
        sum_next             = sum_reg;
        last_next            = last_reg;

        if (remaining_reg != '0)
        begin
            // Length byte: extend the span by payload plus checksum
            if ((remaining_reg == 9'd1) && awaiting_reg)
            begin
                remaining_ext = remaining_reg + {1'b0, rx_byte} + slfc_pkg::CHECK_BYTES;
                awaiting_next = 1'b0;
            end
            result.stored   = 1'b1;
            result.position = count_reg;
            sum_next        = sum_reg + rx_byte;
            last_next       = rx_byte;
            count_next      = count_reg + 9'd1;
            remaining_next  = remaining_ext - 9'd1;
        end
        else
        begin
            // Judge the finished frame, then clear the running sums
            if (count_reg != '0)
            begin
                result.verdict_valid = 1'b1;
                result.checksum_ok   = (sum_less_last == last_reg);
                result.frame_length  = count_reg;
                count_next           = '0;
                sum_next             = '0;
                last_next            = '0;
            end
            // Sync byte opens the next frame and is not kept
            if (rx_byte == sync_value)
            begin
                remaining_next = slfc_pkg::HEADER_SPAN;
                awaiting_next  = 1'b1;
            end
        end
    end

    // Advance the frame state once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            awaiting_reg  <= 1'b1;
            count_reg     <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
        end
        else if (step)
        begin
            remaining_reg <= remaining_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            last_reg      <= last_next;
        end
    end

`ifndef SYNTHESIS
    // A byte is either kept in a frame or closes one, never both
    a_stored_or_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(result.stored && result.verdict_valid))
        else $error("byte both stored and judged");

    // Only the header span is counted while the length byte is still awaited
    a_header_span: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (remaining_reg <= slfc_pkg::HEADER_SPAN))
        else $error("remaining count too large before length byte");

    // Running sums are clear whenever no byte of a frame is held
    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((sum_reg == '0) && (last_reg == '0)))
        else $error("running sums not cleared between frames");

    // A verdict always clears the stored count
    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.verdict_valid) |=> (count_reg == '0))
        else $error("stored count survives a verdict");
`endif

endmodule

// ===== sv/sync_length_frame_checker.sv =====
// Top level of the sync/length frame checker: input stage, result stage and register port.
//
// Checks a byte stream for frames of the form sync, two header bytes, length L, L payload
// bytes and one checksum byte, where the checksum is the 8-bit sum of all kept bytes before
// it. One result leaves for every byte taken. A byte enters the input register, the frame
// logic works on it and its result is held in the output register, so a new byte is taken
// in every cycle unless the result stage stalls on out_ch.ready; the single running-state
// update per byte sets that rate. The verdict for a frame comes with the first byte after it,
// and that byte may open the next frame. The sync value is written over the APB port at
// address 0 (reset 0x7A); the user must do so only while no byte is in flight, and the block does not enforce it.
module sync_length_frame_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    slfc_in_if.sink                       in_ch,
    slfc_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [slfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [slfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic                         in_valid_reg;
    logic [slfc_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         out_valid_reg;
    slfc_pkg::result_t            out_result_reg;
    slfc_pkg::result_t            result;
    logic [slfc_pkg::BYTE_W-1:0]  sync_value_reg;
    logic                         out_free;
    logic                         step;
    logic                         cfg_write;

    // Handshake: move the input stage on whenever the result stage can take it
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || out_free;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.rx_byte;
        end
    end

    slfc_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .sync_value (sync_value_reg),
        .result     (result)
    );

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.stored        = out_result_reg.stored;
    assign out_ch.data          = out_result_reg.data;
    assign out_ch.position      = out_result_reg.position;
    assign out_ch.verdict_valid = out_result_reg.verdict_valid;
    assign out_ch.checksum_ok   = out_result_reg.checksum_ok;
    assign out_ch.frame_length  = out_result_reg.frame_length;

    // Register port: write on the access phase, register index from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= slfc_pkg::SYNC_VALUE_RESET;
        end
        else if (cfg_write && (paddr[2] == slfc_pkg::REG_SYNC_VALUE))
        begin
            sync_value_reg <= pwdata[slfc_pkg::BYTE_W-1:0];
        end
    end

    // Read back the sync value, zero elsewhere
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            slfc_pkg::REG_SYNC_VALUE: prdata[slfc_pkg::BYTE_W-1:0] = sync_value_reg;
            default:                  prdata = '0;
        endcase
    end

endmodule
